// ===== design/dtch_pkg.sv =====
package dtch_pkg;

	// Q16.16 coordinates, 31-bit rod, Q2.30 tilts
	localparam int CW        = 32;
	localparam int ROD_W     = 31;
	localparam int TILT_W    = 32;
	localparam int TILT_FRAC = 30;
	localparam int LO_W      = 24;
	localparam int ROOT_W    = ROD_W;
	localparam int RAD_W     = 2 * ROD_W;
	localparam int TERM_W    = CW + 2;
	localparam int HT_W      = CW + 3;
	localparam int ADDR_W    = 6;
	localparam int DATA_W    = 64;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_OOR = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	typedef struct packed {
		logic signed [CW-1:0] head_x;
		logic signed [CW-1:0] head_y;
		logic signed [CW-1:0] head_z;
		logic [1:0]           tower;
	} pos_t;

	typedef struct packed {
		logic signed [CW-1:0] carriage_height;
		logic [1:0]           status;
	} res_t;

	typedef struct packed {
		logic signed [CW-1:0] tower_a_x;
		logic signed [CW-1:0] tower_a_y;
		logic signed [CW-1:0] tower_b_x;
		logic signed [CW-1:0] tower_b_y;
		logic signed [CW-1:0] tower_c_x;
		logic signed [CW-1:0] tower_c_y;
		logic [ROD_W-1:0]     rod_length;
		logic [DATA_W-1:0]    bed_tilt;
	} cfg_t;

	// data that rides alongside the root pipeline
	typedef struct packed {
		logic signed [HT_W-1:0] ht;
		logic                   oor;
	} side_t;

endpackage

// ===== design/delta_tower_carriage_height_top.sv =====
// Linear delta carriage height for one tower. Each pos word carries a head
// position (Q16.16 mm) and a tower index; the res word gives that tower's
// carriage height sqrt(rod^2 - dx^2 - dy^2) + z + x*xtilt + y*ytilt, the
// root floored and each tilt term rounded to nearest (ties away from zero).
// Status 1 means out of reach (negative radicand or tower index 3, height
// 0); status 2 means the sum clamped to the signed 32-bit range. The block
// takes one word per clock while pos_stall is low and returns results in
// order, through five front stages (offsets, squares, tilt products,
// radicand), then 31 root stages, one result bit each, then
// the output register. Registers sit at byte address 8*i on the APB port:
// 0..5 tower A/B/C x,y, 6 rod length (31 bits), 7 bed tilt (x tilt in
// 63..32, y tilt in 31..0, Q2.30); write them only while the block is idle.
module delta_tower_carriage_height_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dtch_pkg::ADDR_W-1:0] paddr,
	input  logic [dtch_pkg::DATA_W-1:0] pwdata,
	output logic [dtch_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        pos_valid,
	output logic                        pos_stall,
	input  dtch_pkg::pos_t              pos,
	output logic                        res_valid,
	input  logic                        res_stall,
	output dtch_pkg::res_t              res
);
	import dtch_pkg::*;

	localparam int SUM_W = HT_W + 1;
	localparam longint HI_LIM = (longint'(1) << (CW - 1)) - 1;
	localparam longint LO_LIM = -HI_LIM - 1;
	localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(HI_LIM);
	localparam logic signed [SUM_W-1:0] SUM_LO = SUM_W'(LO_LIM);

	cfg_t              cfg;
	logic              pipe_en;
	logic              rad_valid, root_valid;
	logic [RAD_W-1:0]  radicand;
	logic [ROOT_W-1:0] root;
	side_t             side_geom, side_root;
	logic signed [SUM_W-1:0] sum;
	res_t              fin;

	// output register plus one skid word
	res_t res_q, skid_q;
	logic res_valid_q, skid_valid_q;
	logic take;

	dtch_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// whole pipeline moves together; it only halts while the skid is full
	assign pipe_en   = !skid_valid_q;
	assign pos_stall = skid_valid_q;

	dtch_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (pos_valid),
		.pos       (pos),
		.cfg       (cfg),
		.rad_valid (rad_valid),
		.radicand  (radicand),
		.side      (side_geom)
	);

	dtch_sqrt u_sqrt (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (pipe_en),
		.in_valid   (rad_valid),
		.radicand   (radicand),
		.side_i     (side_geom),
		.root_valid (root_valid),
		.root       (root),
		.side_o     (side_root)
	);

	// final add and clamp, straight into the output register
	assign sum = SUM_W'(signed'({1'b0, root})) + SUM_W'(side_root.ht);

	always_comb begin
		if (side_root.oor) begin
			fin.carriage_height = '0;
			fin.status          = ST_OOR;
		end else if (sum > SUM_HI) begin
			fin.carriage_height = SUM_HI[CW-1:0];
			fin.status          = ST_SAT;
		end else if (sum < SUM_LO) begin
			fin.carriage_height = SUM_LO[CW-1:0];
			fin.status          = ST_SAT;
		end else begin
			fin.carriage_height = sum[CW-1:0];
			fin.status          = ST_OK;
		end
	end

	assign take = res_valid_q && !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			// pipeline frozen; skid word moves up once the output drains
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!res_valid_q || take) begin
			res_valid_q <= root_valid;
		end else if (root_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				res_q <= skid_q;
			end
		end else if (!res_valid_q || take) begin
			res_q <= fin;
		end else begin
			skid_q <= fin;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> res_valid_q)
		else $error("skid word held with empty output register");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(res_valid_q && res_stall))
		else $error("skid filled without a stalled output");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_q.status == ST_OOR) |-> (res_q.carriage_height == '0))
		else $error("out-of-reach word with non-zero height");

endmodule

// ===== design/dtch_cfg.sv =====
module dtch_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dtch_pkg::ADDR_W-1:0] paddr,
	input  logic [dtch_pkg::DATA_W-1:0] pwdata,
	output logic [dtch_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output dtch_pkg::cfg_t              cfg
);
	import dtch_pkg::*;

	localparam logic [2:0] REG_AX   = 3'd0;
	localparam logic [2:0] REG_AY   = 3'd1;
	localparam logic [2:0] REG_BX   = 3'd2;
	localparam logic [2:0] REG_BY   = 3'd3;
	localparam logic [2:0] REG_CX   = 3'd4;
	localparam logic [2:0] REG_CY   = 3'd5;
	localparam logic [2:0] REG_ROD  = 3'd6;
	localparam logic [2:0] REG_TILT = 3'd7;

	cfg_t       cfg_q;
	logic [2:0] idx;

	assign idx    = paddr[ADDR_W-1:3];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (idx)
				REG_AX:   cfg_q.tower_a_x  <= pwdata[CW-1:0];
				REG_AY:   cfg_q.tower_a_y  <= pwdata[CW-1:0];
				REG_BX:   cfg_q.tower_b_x  <= pwdata[CW-1:0];
				REG_BY:   cfg_q.tower_b_y  <= pwdata[CW-1:0];
				REG_CX:   cfg_q.tower_c_x  <= pwdata[CW-1:0];
				REG_CY:   cfg_q.tower_c_y  <= pwdata[CW-1:0];
				REG_ROD:  cfg_q.rod_length <= pwdata[ROD_W-1:0];
				REG_TILT: cfg_q.bed_tilt   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_AX:   prdata = {{(DATA_W-CW){1'b0}}, cfg_q.tower_a_x};
			REG_AY:   prdata = {{(DATA_W-CW){1'b0}}, cfg_q.tower_a_y};
			REG_BX:   prdata = {{(DATA_W-CW){1'b0}}, cfg_q.tower_b_x};
			REG_BY:   prdata = {{(DATA_W-CW){1'b0}}, cfg_q.tower_b_y};
			REG_CX:   prdata = {{(DATA_W-CW){1'b0}}, cfg_q.tower_c_x};
			REG_CY:   prdata = {{(DATA_W-CW){1'b0}}, cfg_q.tower_c_y};
			REG_ROD:  prdata = {{(DATA_W-ROD_W){1'b0}}, cfg_q.rod_length};
			REG_TILT: prdata = cfg_q.bed_tilt;
			default:  prdata = '0;
		endcase
	end

endmodule

// ===== design/dtch_geom.sv =====
module dtch_geom (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  dtch_pkg::pos_t             pos,
	input  dtch_pkg::cfg_t             cfg,
	output logic                       rad_valid,
	output logic [dtch_pkg::RAD_W-1:0] radicand,
	output dtch_pkg::side_t            side
);
	import dtch_pkg::*;

	localparam logic [1:0] TOWER_A = 2'd0;
	localparam logic [1:0] TOWER_B = 2'd1;
	localparam logic [1:0] TOWER_C = 2'd2;
	localparam int HI_W  = CW - LO_W + TILT_W;
	localparam int LOP_W = LO_W + TILT_W;

	function automatic logic [CW-1:0] mag_c(input logic signed [CW-1:0] v);
		logic [CW-1:0] u;
		u = v;
		return v[CW-1] ? (~u + 1'b1) : u;
	endfunction

	// stage 1 inputs
	logic signed [CW-1:0]     tx, ty, xt, yt;
	logic                     bad;
	// stage 1
	logic                     vld_s1, bad_s1, negx_s1, negy_s1;
	logic signed [CW-1:0]     hz_s1;
	logic signed [CW:0]       dxs_s1, dys_s1;
	logic [CW-1:0]            max_s1, may_s1, mtx_s1, mty_s1;
	// stage 2
	logic                     vld_s2, bad_s2, negx_s2, negy_s2;
	logic signed [CW-1:0]     hz_s2;
	logic [CW:0]              dx_s2, dy_s2;
	logic [LOP_W-1:0]         lox_s2, loy_s2;
	logic [HI_W-1:0]          hix_s2, hiy_s2;
	// stage 3
	logic                     vld_s3, oor_s3, negx_s3, negy_s3;
	logic signed [CW-1:0]     hz_s3;
	logic [RAD_W-1:0]         r2_s3, dx2_s3, dy2_s3;
	logic [TERM_W-2:0]        rx_s3, ry_s3;
	// stage 4
	logic                     vld_s4, oor_s4;
	logic signed [CW-1:0]     hz_s4;
	logic [RAD_W-1:0]         rem_s4, dy2_s4;
	logic signed [TERM_W-1:0] tx_s4, ty_s4;
	// stage 5
	logic                     vld_s5, oor_s5;
	logic [RAD_W-1:0]         rad_s5;
	logic signed [HT_W-1:0]   ht_s5;

	// comb helpers
	logic [CW:0]              ux, uy;
	logic [2*DATA_W/2-1:0]    totx, toty;
	logic signed [TERM_W-1:0] px, py;
	logic [RAD_W:0]           d1, d2;

	always_comb begin
		bad = 1'b0;
		case (pos.tower)
			TOWER_A: begin
				tx = cfg.tower_a_x;
				ty = cfg.tower_a_y;
			end
			TOWER_B: begin
				tx = cfg.tower_b_x;
				ty = cfg.tower_b_y;
			end
			TOWER_C: begin
				tx = cfg.tower_c_x;
				ty = cfg.tower_c_y;
			end
			default: begin
				tx  = '0;
				ty  = '0;
				bad = 1'b1;
			end
		endcase
	end

	assign xt = cfg.bed_tilt[DATA_W-1:TILT_W];
	assign yt = cfg.bed_tilt[TILT_W-1:0];

	assign ux = dxs_s1;
	assign uy = dys_s1;

	// rounded tilt magnitudes: (hi << 24) + lo + half, then drop 30 bits
	assign totx = (DATA_W'(hix_s2) << LO_W) + DATA_W'(lox_s2)
		+ (DATA_W'(1) << (TILT_FRAC - 1));
	assign toty = (DATA_W'(hiy_s2) << LO_W) + DATA_W'(loy_s2)
		+ (DATA_W'(1) << (TILT_FRAC - 1));

	assign px = {1'b0, rx_s3};
	assign py = {1'b0, ry_s3};
	assign d1 = {1'b0, r2_s3} - {1'b0, dx2_s3};
	assign d2 = {1'b0, rem_s4} - {1'b0, dy2_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: offsets from tower, operand magnitudes for the tilt products
			bad_s1  <= bad;
			hz_s1   <= pos.head_z;
			dxs_s1  <= {pos.head_x[CW-1], pos.head_x} - {tx[CW-1], tx};
			dys_s1  <= {pos.head_y[CW-1], pos.head_y} - {ty[CW-1], ty};
			max_s1  <= mag_c(pos.head_x);
			may_s1  <= mag_c(pos.head_y);
			mtx_s1  <= mag_c(xt);
			mty_s1  <= mag_c(yt);
			negx_s1 <= pos.head_x[CW-1] ^ xt[CW-1];
			negy_s1 <= pos.head_y[CW-1] ^ yt[CW-1];
			// s2: offset magnitudes, split tilt products
			bad_s2  <= bad_s1;
			hz_s2   <= hz_s1;
			negx_s2 <= negx_s1;
			negy_s2 <= negy_s1;
			dx_s2   <= dxs_s1[CW] ? (~ux + 1'b1) : ux;
			dy_s2   <= dys_s1[CW] ? (~uy + 1'b1) : uy;
			lox_s2  <= max_s1[LO_W-1:0] * mtx_s1;
			loy_s2  <= may_s1[LO_W-1:0] * mty_s1;
			hix_s2  <= max_s1[CW-1:LO_W] * mtx_s1;
			hiy_s2  <= may_s1[CW-1:LO_W] * mty_s1;
			// s3: reach check, squares, tilt rounding
			oor_s3  <= bad_s2 || (dx_s2 > cfg.rod_length) || (dy_s2 > cfg.rod_length);
			hz_s3   <= hz_s2;
			negx_s3 <= negx_s2;
			negy_s3 <= negy_s2;
			r2_s3   <= cfg.rod_length * cfg.rod_length;
			dx2_s3  <= dx_s2[ROD_W-1:0] * dx_s2[ROD_W-1:0];
			dy2_s3  <= dy_s2[ROD_W-1:0] * dy_s2[ROD_W-1:0];
			rx_s3   <= totx[TILT_FRAC +: TERM_W-1];
			ry_s3   <= toty[TILT_FRAC +: TERM_W-1];
			// s4: r2 - dx2, signed tilt terms
			oor_s4  <= oor_s3 | d1[RAD_W];
			rem_s4  <= d1[RAD_W-1:0];
			dy2_s4  <= dy2_s3;
			hz_s4   <= hz_s3;
			tx_s4   <= negx_s3 ? -px : px;
			ty_s4   <= negy_s3 ? -py : py;
			// s5: final radicand, height offset
			oor_s5  <= oor_s4 | d2[RAD_W];
			rad_s5  <= d2[RAD_W-1:0];
			ht_s5   <= HT_W'(hz_s4) + HT_W'(tx_s4) + HT_W'(ty_s4);
		end
	end

	assign rad_valid = vld_s5;
	assign radicand  = rad_s5;
	assign side.ht   = ht_s5;
	assign side.oor  = oor_s5;

	a_oor_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s4 && oor_s4 |=> oor_s5)
		else $error("out-of-reach flag lost between stages");

endmodule

// ===== design/dtch_sqrt.sv =====
module dtch_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [dtch_pkg::RAD_W-1:0]  radicand,
	input  dtch_pkg::side_t             side_i,
	output logic                        root_valid,
	output logic [dtch_pkg::ROOT_W-1:0] root,
	output dtch_pkg::side_t             side_o
);
	import dtch_pkg::*;

	localparam int REM_W = ROOT_W + 3;

	logic               vld_s  [ROOT_W];
	logic [RAD_W-1:0]   rad_s  [ROOT_W];
	logic [REM_W-1:0]   rem_s  [ROOT_W];
	logic [ROOT_W-1:0]  root_s [ROOT_W];
	side_t              side_s [ROOT_W];

	// one result bit per stage, restoring digit recurrence
	for (genvar k = 0; k < ROOT_W; k++) begin : g_step
		localparam int PAIR = ROOT_W - 1 - k;
		logic              vld_in;
		logic [RAD_W-1:0]  rad_in;
		logic [REM_W-1:0]  rem_in, cand, trial;
		logic [ROOT_W-1:0] root_in;
		side_t             side_in;
		logic              ge;

		if (k == 0) begin : g_first
			assign vld_in  = in_valid;
			assign rad_in  = radicand;
			assign rem_in  = '0;
			assign root_in = '0;
			assign side_in = side_i;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign side_in = side_s[k-1];
		end

		assign cand  = {rem_in[REM_W-3:0], rad_in[2*PAIR+1 -: 2]};
		assign trial = REM_W'({root_in, 2'b01});
		assign ge    = cand >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= rad_in;
				rem_s[k]  <= ge ? (cand - trial) : cand;
				root_s[k] <= {root_in[ROOT_W-2:0], ge};
				side_s[k] <= side_in;
			end
		end
	end

	assign root_valid = vld_s[ROOT_W-1];
	assign root       = root_s[ROOT_W-1];
	assign side_o     = side_s[ROOT_W-1];

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ROOT_W-1] |-> rem_s[ROOT_W-1] <= REM_W'({root_s[ROOT_W-1], 1'b0}))
		else $error("root remainder above 2*root");

endmodule

// ===== sim/dtch_checker.sv =====
package dtch_tb_pkg;

	// register map, byte address = index * 8
	typedef enum int {
		REG_TOWER_A_X,
		REG_TOWER_A_Y,
		REG_TOWER_B_X,
		REG_TOWER_B_Y,
		REG_TOWER_C_X,
		REG_TOWER_C_Y,
		REG_ROD_LENGTH,
		REG_BED_TILT
	} reg_idx_e;

	localparam int REG_STRIDE = 8;

	localparam logic [1:0] TOWER_A    = 2'd0;
	localparam logic [1:0] TOWER_B    = 2'd1;
	localparam logic [1:0] TOWER_C    = 2'd2;
	localparam logic [1:0] TOWER_NONE = 2'd3;

endpackage

module dtch_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [dtch_pkg::ADDR_W-1:0] paddr,
	input  logic [dtch_pkg::DATA_W-1:0] pwdata,
	input  logic                        pos_valid,
	input  logic                        pos_stall,
	input  dtch_pkg::pos_t              pos,
	input  logic                        res_valid,
	input  logic                        res_stall,
	input  dtch_pkg::res_t              res,
	output int                          fails,
	output int                          pending
);

	timeunit 1ns;
	timeprecision 1ps;

	import dtch_pkg::*;
	import dtch_tb_pkg::*;

	localparam longint HEIGHT_MAX = (longint'(1) << (CW - 1)) - 1;
	localparam longint HEIGHT_MIN = -HEIGHT_MAX - 1;

	cfg_t   geometry = '0;
	res_t   expected_heights[$];
	int     mismatch_count = 0;

	function automatic longint unsigned distance(input longint d);
		return (d < 0) ? longint'(-d) : d;
	endfunction

	// floor of the square root, one result bit per pass
	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned acc;
		longint unsigned trial;
		acc = 0;
		for (int b = ROOT_W - 1; b >= 0; b--) begin
			trial = acc | (64'd1 << b);
			if (trial * trial <= v)
				acc = trial;
		end
		return acc;
	endfunction

	// coordinate times Q2.30 tilt, nearest, ties away from zero
	function automatic longint tilt_term(input longint a, input longint tilt);
		longint unsigned prod;
		longint unsigned q;
		prod = distance(a) * distance(tilt);
		q    = (prod + (64'd1 << (TILT_FRAC - 1))) >> TILT_FRAC;
		return ((a < 0) != (tilt < 0)) ? -longint'(q) : longint'(q);
	endfunction

	function automatic res_t predict_height(input pos_t p, input cfg_t c);
		res_t            r;
		longint          tx, ty, sum;
		longint unsigned rod, dx, dy, r2, dx2, dy2, root;
		r.carriage_height = '0;
		r.status          = ST_OOR;
		case (p.tower)
			TOWER_A: begin
				tx = longint'(c.tower_a_x);
				ty = longint'(c.tower_a_y);
			end
			TOWER_B: begin
				tx = longint'(c.tower_b_x);
				ty = longint'(c.tower_b_y);
			end
			TOWER_C: begin
				tx = longint'(c.tower_c_x);
				ty = longint'(c.tower_c_y);
			end
			default: return r;
		endcase
		rod = c.rod_length;
		dx  = distance(longint'(p.head_x) - tx);
		dy  = distance(longint'(p.head_y) - ty);
		if (dx > rod || dy > rod)
			return r;
		r2  = rod * rod;
		dx2 = dx * dx;
		dy2 = dy * dy;
		if (dx2 + dy2 > r2)
			return r;
		root = floor_root(r2 - dx2 - dy2);
		sum  = longint'(root) + longint'(p.head_z)
			+ tilt_term(longint'(p.head_x), longint'($signed(c.bed_tilt[63:32])))
			+ tilt_term(longint'(p.head_y), longint'($signed(c.bed_tilt[31:0])));
		r.status = ST_OK;
		if (sum > HEIGHT_MAX) begin
			sum      = HEIGHT_MAX;
			r.status = ST_SAT;
		end else if (sum < HEIGHT_MIN) begin
			sum      = HEIGHT_MIN;
			r.status = ST_SAT;
		end
		r.carriage_height = sum[CW-1:0];
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input logic [CW-1:0] got,
			input logic [CW-1:0] want);
		mismatch_count++;
		$display("%0t ns: %s: got %h, want %h", $time, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			geometry = '0;
			expected_heights.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (int'(paddr) / REG_STRIDE)
					REG_TOWER_A_X:  geometry.tower_a_x  = pwdata[CW-1:0];
					REG_TOWER_A_Y:  geometry.tower_a_y  = pwdata[CW-1:0];
					REG_TOWER_B_X:  geometry.tower_b_x  = pwdata[CW-1:0];
					REG_TOWER_B_Y:  geometry.tower_b_y  = pwdata[CW-1:0];
					REG_TOWER_C_X:  geometry.tower_c_x  = pwdata[CW-1:0];
					REG_TOWER_C_Y:  geometry.tower_c_y  = pwdata[CW-1:0];
					REG_ROD_LENGTH: geometry.rod_length = pwdata[ROD_W-1:0];
					REG_BED_TILT:   geometry.bed_tilt   = pwdata;
					default: ;
				endcase
			end
			if (pos_valid && !pos_stall)
				expected_heights.push_back(predict_height(pos, geometry));
			if (res_valid && !res_stall) begin
				if (expected_heights.size() == 0) begin
					flag_mismatch("res word with nothing expected", res.carriage_height, '0);
				end else begin
					want = expected_heights.pop_front();
					if (res.carriage_height !== want.carriage_height)
						flag_mismatch("carriage_height", res.carriage_height,
							want.carriage_height);
					if (res.status !== want.status)
						flag_mismatch("status", CW'(res.status), CW'(want.status));
				end
			end
		end
		fails   <= mismatch_count;
		pending <= expected_heights.size();
	end

endmodule

// ===== sim/tb_delta_tower_carriage_height_top.sv =====
module tb_delta_tower_carriage_height_top;

	timeunit 1ns;
	timeprecision 1ps;

	import dtch_pkg::*;
	import dtch_tb_pkg::*;

	// give the pipeline slack before touching registers
	localparam int HOLD_OFF       = 48;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_WORDS   = 96;   // per phase, six phases

	localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic [ROD_W-1:0]     ROD_MAX   = '1;

	// a plausible printer: towers on a 100 mm circle
	localparam int TA_X = -5675418;
	localparam int TA_Y = -3276800;
	localparam int TB_X = 5675418;
	localparam int TB_Y = -3276800;
	localparam int TC_X = 0;
	localparam int TC_Y = 6553600;
	localparam int ROD_TOP = 2147483647;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              pos_valid;
	logic              pos_stall;
	pos_t              pos;
	logic              res_valid;
	logic              res_stall;
	res_t              res;

	int fails;
	int pending;
	int send_idle;
	int recv_idle;
	int quiet_cycles;

	delta_tower_carriage_height_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.pos_valid (pos_valid),
		.pos_stall (pos_stall),
		.pos       (pos),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	dtch_checker height_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.pready    (pready),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.pos_valid (pos_valid),
		.pos_stall (pos_stall),
		.pos       (pos),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.fails     (fails),
		.pending   (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver side: stall at random, rate set per phase
	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < recv_idle);
	end

	// watchdog: any word moved on either channel, or a register access,
	// counts as progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pos_valid && !pos_stall) || (res_valid && !res_stall) || (psel && penable))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("** delta_tower_carriage_height_top: FAILED **");
				$finish;
			end
		end
	end

	// APB write with setup and access phases; psel is left high so back-to-back
	// writes never drop and raise it in the same step, the caller closes the burst
	task automatic apb_write(input reg_idx_e idx, input logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(int'(idx) * REG_STRIDE);
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	// upper bits of narrow registers carry junk; the block must drop them
	task automatic load_geometry(input cfg_t c);
		apb_write(REG_TOWER_A_X, {32'($urandom), c.tower_a_x});
		apb_write(REG_TOWER_A_Y, {32'($urandom), c.tower_a_y});
		apb_write(REG_TOWER_B_X, {32'($urandom), c.tower_b_x});
		apb_write(REG_TOWER_B_Y, {32'($urandom), c.tower_b_y});
		apb_write(REG_TOWER_C_X, {32'($urandom), c.tower_c_x});
		apb_write(REG_TOWER_C_Y, {32'($urandom), c.tower_c_y});
		apb_write(REG_ROD_LENGTH, {32'($urandom), 1'($urandom), c.rod_length});
		apb_write(REG_BED_TILT, c.bed_tilt);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// one pos word, with random idle cycles ahead of it; returns at the
	// edge where the word is taken
	task automatic push_pos(input pos_t p);
		while ($urandom_range(99) < send_idle) begin
			pos_valid <= 1'b0;
			@(posedge clk);
		end
		pos_valid <= 1'b1;
		pos       <= p;
		do @(posedge clk); while (pos_stall);
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic pos_t head_word(input logic signed [CW-1:0] x,
			input logic signed [CW-1:0] y, input logic signed [CW-1:0] z,
			input logic [1:0] t);
		pos_t p;
		p.head_x = x;
		p.head_y = y;
		p.head_z = z;
		p.tower  = t;
		return p;
	endfunction

	// a coordinate up to span away from centre, clamped to the Q16.16 range
	function automatic logic signed [CW-1:0] near_coord(input longint centre,
			input longint span);
		longint v;
		v = centre;
		if (span > 0)
			v = centre + longint'($signed($urandom)) % (span + 1);
		if (v > longint'(COORD_MAX))
			v = longint'(COORD_MAX);
		if (v < longint'(COORD_MIN))
			v = longint'(COORD_MIN);
		return v[CW-1:0];
	endfunction

	function automatic logic signed [CW-1:0] edge_coord(input logic signed [CW-1:0] t);
		case ($urandom_range(5))
			0:       return COORD_MAX;
			1:       return COORD_MIN;
			2:       return '0;
			3:       return '1;
			4:       return CW'(1);
			default: return t;
		endcase
	endfunction

	// mostly positions within a rod's reach of the chosen tower, so the
	// root and tilt paths see real work; the rest is raw noise and edges
	function automatic pos_t random_head(input cfg_t c);
		pos_t                  p;
		int                    kind;
		int                    zv;
		longint                span;
		logic signed [CW-1:0]  tx, ty;
		kind    = $urandom_range(99);
		p.tower = ($urandom_range(19) == 0) ? TOWER_NONE : 2'($urandom_range(TOWER_C));
		case (p.tower)
			TOWER_A: begin tx = c.tower_a_x; ty = c.tower_a_y; end
			TOWER_B: begin tx = c.tower_b_x; ty = c.tower_b_y; end
			TOWER_C: begin tx = c.tower_c_x; ty = c.tower_c_y; end
			default: begin tx = '0; ty = '0; end
		endcase
		if (kind < 70) begin
			// a little over the rod now and then to graze the reach boundary
			span = longint'(c.rod_length);
			if ($urandom_range(3) == 0)
				span = span + span / 8;
			else
				span = span * 7 / 10;
			p.head_x = near_coord(longint'(tx), span);
			p.head_y = near_coord(longint'(ty), span);
			zv       = $urandom;
			p.head_z = zv >>> $urandom_range(4, 20);
		end else if (kind < 90) begin
			p = pos_t'({$urandom, $urandom, $urandom, 2'($urandom)});
		end else begin
			p.head_x = edge_coord(tx);
			p.head_y = edge_coord(ty);
			p.head_z = edge_coord('0);
		end
		return p;
	endfunction

	// extremes of every field, reach boundary, tower index 3, saturation
	// both ways and the rounding ties of the 0.5 / -0.5 tilts
	task automatic directed_words();
		push_pos(head_word(TA_X, TA_Y, 0, TOWER_A));
		push_pos(head_word(TB_X, TB_Y, 0, TOWER_B));
		push_pos(head_word(TC_X, TC_Y, 0, TOWER_C));
		push_pos(head_word(0, 0, 0, TOWER_NONE));
		push_pos(head_word(TA_X, TA_Y, 0, TOWER_NONE));
		push_pos(head_word(COORD_MAX, COORD_MAX, COORD_MAX, TOWER_NONE));
		// radicand exactly zero, then one LSB out
		push_pos(head_word(TA_X + ROD_TOP, TA_Y, 0, TOWER_A));
		push_pos(head_word(TA_X + ROD_TOP + 1, TA_Y, 0, TOWER_A));
		// each offset alone in reach, the sum of squares not
		push_pos(head_word(TA_X + 1610612735, TA_Y + 1610612735, 0, TOWER_A));
		push_pos(head_word(COORD_MIN, TA_Y, COORD_MIN, TOWER_A));
		push_pos(head_word(TA_X, TA_Y, COORD_MAX, TOWER_A));
		push_pos(head_word(COORD_MAX, TB_Y, COORD_MAX, TOWER_B));
		push_pos(head_word(1, 1, 0, TOWER_C));
		push_pos(head_word(-1, -1, 0, TOWER_C));
		push_pos(head_word(3, -3, 0, TOWER_C));
		push_pos(head_word(0, COORD_MAX, 0, TOWER_C));
		push_pos(head_word(0, COORD_MIN, 0, TOWER_C));
		push_pos(head_word(0, 0, COORD_MIN, TOWER_B));
		push_pos(head_word(-1, -1, -1, TOWER_B));
	endtask

	// registers only change with the pipe empty; pos_valid is already low
	// on entry
	task automatic run_phase(input cfg_t c, input int s_idle, input int r_idle,
			input bit with_directed);
		wait_drained();
		repeat (HOLD_OFF) @(posedge clk);
		load_geometry(c);
		send_idle = s_idle;
		recv_idle = r_idle;
		if (with_directed)
			directed_words();
		repeat (RANDOM_WORDS)
			push_pos(random_head(c));
		pos_valid <= 1'b0;
	endtask

	initial begin
		cfg_t c;
		clk          = 1'b0;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		pos_valid    = 1'b0;
		pos          = '0;
		res_stall    = 1'b0;
		send_idle    = 0;
		recv_idle    = 0;
		quiet_cycles = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// longest rod, realistic towers, tilts of +0.5 and -0.5
		c.tower_a_x  = TA_X;
		c.tower_a_y  = TA_Y;
		c.tower_b_x  = TB_X;
		c.tower_b_y  = TB_Y;
		c.tower_c_x  = TC_X;
		c.tower_c_y  = TC_Y;
		c.rod_length = ROD_MAX;
		c.bed_tilt   = {32'h2000_0000, 32'he000_0000};
		run_phase(c, 37, 46, 1'b1);

		// 250 mm rod, a whisker of tilt
		c.rod_length = 31'd16384000;
		c.bed_tilt   = {32'($signed($urandom) >>> 11), 32'($signed($urandom) >>> 11)};
		run_phase(c, 37, 46, 1'b0);

		// towers at the corners of the range, tilts at full scale
		c.tower_a_x  = '0;
		c.tower_a_y  = '0;
		c.tower_b_x  = COORD_MIN;
		c.tower_b_y  = COORD_MIN;
		c.tower_c_x  = COORD_MAX;
		c.tower_c_y  = COORD_MAX;
		c.rod_length = ROD_MAX;
		c.bed_tilt   = {32'h8000_0000, 32'h7fff_ffff};
		run_phase(c, 46, 37, 1'b0);

		// zero rod: only a head sitting on the tower is in reach
		c.tower_a_x  = $urandom;
		c.tower_a_y  = $urandom;
		c.tower_b_x  = $urandom;
		c.tower_b_y  = $urandom;
		c.tower_c_x  = $urandom;
		c.tower_c_y  = $urandom;
		c.rod_length = '0;
		c.bed_tilt   = '0;
		run_phase(c, 46, 37, 1'b0);

		// everything random
		c.tower_a_x  = $urandom;
		c.tower_a_y  = $urandom;
		c.tower_b_x  = $urandom;
		c.tower_b_y  = $urandom;
		c.tower_c_x  = $urandom;
		c.tower_c_y  = $urandom;
		c.rod_length = 31'($urandom);
		c.bed_tilt   = {32'($urandom), 32'($urandom)};
		run_phase(c, 0, 0, 1'b0);

		// small machine, 200..400 mm rod, any tilt
		c.tower_a_x  = $signed($urandom) >>> 8;
		c.tower_a_y  = $signed($urandom) >>> 8;
		c.tower_b_x  = $signed($urandom) >>> 8;
		c.tower_b_y  = $signed($urandom) >>> 8;
		c.tower_c_x  = $signed($urandom) >>> 8;
		c.tower_c_y  = $signed($urandom) >>> 8;
		c.rod_length = 31'(13107200 + $urandom_range(13107200));
		c.bed_tilt   = {32'($urandom), 32'($urandom)};
		run_phase(c, 0, 0, 1'b0);

		// let the last words out, then watch a while for strays
		wait_drained();
		repeat (HOLD_OFF) @(posedge clk);
		if (fails == 0)
			$display("** delta_tower_carriage_height_top: PASSED **");
		else
			$display("** delta_tower_carriage_height_top: FAILED **");
		$finish;
	end

endmodule
